/* design/rsg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsg_pkg
// Shared types and constants for the replacement selection run generator.
// ----------------------------------------------------------------------------
package rsg_pkg;

    localparam int VALUE_W    = 32;
    localparam int TAPE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_COUNT = 2'd1;

    typedef struct packed {
        logic               last;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic               final_beat;
        logic               run_first;
        logic [TAPE_W-1:0]  tape;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

/* design/replacement_selection_run_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replacement_selection_run_gen
// Streaming run generator for external sort, replacement selection on a
// min-heap, with drain of the heap and of frozen values on the last beat.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tdata: in_value[31:0]; tlast: in_last
//  m_axis   | out       | tdata: out_value, out_tape; tuser: run_first;
//           |           | tlast: out_final
//  cfg      | in        | index 0 heap_size, index 1 tape_count; data 5 bits
//
//  A fill beat is written straight into the heap memory; a stream beat walks
//  the sift down the heap levels, and the next beat is taken only in idle.
//  A reheap costs heap_size/2 sifts; a drain costs one sift per value, the
//  frozen copy a read and a write per entry. The single-write heap memory sets this.
//  Reset and any register write restart the stream; heap contents are kept.
//  A two-beat input queue keeps s_axis open while the core works, and the
//  m_axis output register holds a beat until taken, stalling the core only.
// ----------------------------------------------------------------------------
module replacement_selection_run_gen #(
    parameter int HEAP_DEPTH = 16,
    parameter int MAX_TAPES  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsg_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // in_value[31:0]
    input  logic                           s_axis_tlast,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,   // out_value[31:0], out_tape[34:32]
    output logic                           m_axis_tuser,   // run_first
    output logic                           m_axis_tlast
);
    import rsg_pkg::*;

    item_t   s_item, q_item;
    logic    q_valid, q_ready;
    result_t res;

    assign s_item = '{last: s_axis_tlast, value: s_axis_tdata};

    // hold incoming beats while the core sifts
    rsg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // heap sequencer and output register
    rsg_core #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .MAX_TAPES  (MAX_TAPES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res)
    );

    // pack result fields, lowest bit first, zero fill to whole bytes
    assign m_axis_tdata = {5'd0, res.tape, res.value};
    assign m_axis_tuser = res.run_first;
    assign m_axis_tlast = res.final_beat;

endmodule

/* design/rsg_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsg_queue
// Two-entry queue that takes input beats and hands them to the sort core.
// ----------------------------------------------------------------------------
module rsg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rsg_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rsg_pkg::item_t out_item
);
    import rsg_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* design/rsg_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsg_core
// Heap sequencer: fill, build, replace-and-sift, drain and final frozen run.
// ----------------------------------------------------------------------------
module rsg_core #(
    parameter int HEAP_DEPTH = 16,
    parameter int MAX_TAPES  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rsg_pkg::item_t                     in_item,
    output logic                               res_valid,
    input  logic                               res_ready,
    output rsg_pkg::result_t                   res_data
);
    import rsg_pkg::*;

    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int AW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int TCW = $clog2(MAX_TAPES + 1);
    localparam int TW  = (MAX_TAPES > 1) ? $clog2(MAX_TAPES) : 1;
    localparam int HS_RST = (HEAP_DEPTH < 16) ? HEAP_DEPTH : 16;
    localparam int TC_RST = (MAX_TAPES < 2) ? MAX_TAPES : 2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BLD  = 4'd1;
    localparam logic [3:0] S_SLD  = 4'd2;
    localparam logic [3:0] S_SX   = 4'd3;
    localparam logic [3:0] S_SC   = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_RRD  = 4'd6;
    localparam logic [3:0] S_ROOT = 4'd7;
    localparam logic [3:0] S_POST = 4'd8;
    localparam logic [3:0] S_DRD  = 4'd9;
    localparam logic [3:0] S_DRN  = 4'd10;
    localparam logic [3:0] S_CRD  = 4'd11;
    localparam logic [3:0] S_CWR  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [VALUE_W-1:0] heap_mem [HEAP_DEPTH];

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      hs_reg, hs_next;
    logic [TCW-1:0]     tc_reg, tc_next;
    logic [TW-1:0]      tape_reg, tape_next;
    logic [CW-1:0]      active_reg, active_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               run_open_reg, run_open_next;
    logic [VALUE_W-1:0] v_reg, v_next;
    logic               last_reg, last_next;
    logic [VALUE_W-1:0] x_reg, x_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [3:0]         ret_reg, ret_next;
    logic [CW-1:0]      bld_i_reg, bld_i_next;
    logic [CW-1:0]      bld_n_reg, bld_n_next;
    logic [3:0]         bld_ret_reg, bld_ret_next;
    logic [CW-1:0]      drn_n_reg, drn_n_next;
    logic               drn_first_reg, drn_first_next;
    logic               drn_frozen_reg, drn_frozen_next;
    logic [CW-1:0]      frz_reg, frz_next;
    logic [CW-1:0]      cp_j_reg, cp_j_next;
    logic [CW-1:0]      cp_base_reg, cp_base_next;
    logic               root_first_reg, root_first_next;
    logic [VALUE_W-1:0] rd0_reg, rd1_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    logic               we;
    logic [AW-1:0]      wa, ra0, ra1;
    logic [VALUE_W-1:0] wd;

    logic               out_free, cfg_wr, in_take;
    logic [CW:0]        l_c, r_c, sl_c;
    logic               lv, rv, take_l, take_r;
    logic [VALUE_W-1:0] best;
    logic [AW-1:0]      s_c;
    logic [CW-1:0]      am1, nm1, fill_inc, cp_src;
    logic [TCW-1:0]     tape_inc;
    logic [TW-1:0]      tape_adv;
    logic [CW-1:0]      hs_cfg;
    logic [TCW-1:0]     tc_cfg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_res_reg;

    // heap index arithmetic
    always_comb begin
        l_c      = {CW'(i_reg), 1'b1};
        r_c      = l_c + (CW + 1)'(1);
        lv       = (l_c < {1'b0, n_reg});
        rv       = (r_c < {1'b0, n_reg});
        best     = x_reg;
        take_l   = 1'b0;
        take_r   = 1'b0;
        if (lv && ($signed(rd0_reg) < $signed(x_reg))) begin
            take_l = 1'b1;
            best   = rd0_reg;
        end
        if (rv && ($signed(rd1_reg) < $signed(best))) begin
            take_r = 1'b1;
            take_l = 1'b0;
            best   = rd1_reg;
        end
        s_c      = take_r ? r_c[AW-1:0] : l_c[AW-1:0];
        sl_c     = {CW'(s_c), 1'b1};
        am1      = active_reg - CW'(1);
        nm1      = drn_n_reg - CW'(1);
        fill_inc = fill_reg + CW'(1);
        cp_src   = cp_base_reg + cp_j_reg;
        tape_inc = TCW'(tape_reg) + TCW'(1);
        tape_adv = (tape_inc == tc_reg) ? TW'(0) : TW'(tape_inc);
    end

    // clamp register writes
    always_comb begin
        hs_cfg = CW'(cfg_data);
        if (cfg_data == '0) begin
            hs_cfg = CW'(1);
        end else if (32'(cfg_data) > HEAP_DEPTH) begin
            hs_cfg = CW'(HEAP_DEPTH);
        end
        tc_cfg = TCW'(cfg_data[3:0]);
        if (cfg_data[3:0] == 4'd0) begin
            tc_cfg = TCW'(1);
        end else if (32'(cfg_data[3:0]) > MAX_TAPES) begin
            tc_cfg = TCW'(MAX_TAPES);
        end
    end

    always_comb begin
        state_next      = state_reg;
        hs_next         = hs_reg;
        tc_next         = tc_reg;
        tape_next       = tape_reg;
        active_next     = active_reg;
        fill_next       = fill_reg;
        run_open_next   = run_open_reg;
        v_next          = v_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        i_next          = i_reg;
        n_next          = n_reg;
        ret_next        = ret_reg;
        bld_i_next      = bld_i_reg;
        bld_n_next      = bld_n_reg;
        bld_ret_next    = bld_ret_reg;
        drn_n_next      = drn_n_reg;
        drn_first_next  = drn_first_reg;
        drn_frozen_next = drn_frozen_reg;
        frz_next        = frz_reg;
        cp_j_next       = cp_j_reg;
        cp_base_next    = cp_base_reg;
        root_first_next = root_first_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_res_next    = out_res_reg;
        we  = 1'b0;
        wa  = '0;
        wd  = v_reg;
        ra0 = '0;
        ra1 = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    v_next    = in_item.value;
                    last_next = in_item.last;
                    if (fill_reg < hs_reg) begin
                        we        = 1'b1;
                        wa        = fill_reg[AW-1:0];
                        wd        = in_item.value;
                        fill_next = fill_inc;
                        if (in_item.last) begin
                            drn_n_next      = fill_inc;
                            drn_first_next  = 1'b1;
                            drn_frozen_next = 1'b0;
                            frz_next        = '0;
                            bld_n_next      = fill_inc;
                            bld_i_next      = fill_inc >> 1;
                            bld_ret_next    = S_DRD;
                            state_next      = S_BLD;
                        end else if (fill_inc == hs_reg) begin
                            active_next  = hs_reg;
                            bld_n_next   = hs_reg;
                            bld_i_next   = hs_reg >> 1;
                            bld_ret_next = S_IDLE;
                            state_next   = S_BLD;
                        end
                    end else if (active_reg == '0) begin
                        // run exhausted: reheap everything, open a new run
                        active_next     = hs_reg;
                        root_first_next = 1'b1;
                        if (run_open_reg) begin
                            tape_next = tape_adv;
                        end
                        bld_n_next   = hs_reg;
                        bld_i_next   = hs_reg >> 1;
                        bld_ret_next = S_RRD;
                        state_next   = S_BLD;
                    end else begin
                        root_first_next = !run_open_reg;
                        state_next      = S_RRD;
                    end
                end
            end
            S_BLD: begin
                if (bld_i_reg == '0) begin
                    state_next = bld_ret_reg;
                end else begin
                    i_next     = AW'(bld_i_reg - CW'(1));
                    bld_i_next = bld_i_reg - CW'(1);
                    n_next     = bld_n_reg;
                    ret_next   = S_BLD;
                    state_next = S_SLD;
                end
            end
            S_SLD: begin
                ra0        = i_reg;
                state_next = S_SX;
            end
            S_SX: begin
                x_next     = rd0_reg;
                ra0        = l_c[AW-1:0];
                ra1        = r_c[AW-1:0];
                state_next = S_CMP;
            end
            S_SC: begin
                ra0        = l_c[AW-1:0];
                ra1        = r_c[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP: begin
                we = 1'b1;
                wa = i_reg;
                if (take_l || take_r) begin
                    // move smaller child up, follow the hole down
                    wd     = best;
                    i_next = s_c;
                    ra0    = sl_c[AW-1:0];
                    ra1    = AW'(sl_c + (CW + 1)'(1));
                end else begin
                    wd         = x_reg;
                    state_next = ret_reg;
                end
            end
            S_RRD: begin
                ra0        = '0;
                ra1        = am1[AW-1:0];
                state_next = S_ROOT;
            end
            S_ROOT: begin
                ra0 = '0;
                ra1 = am1[AW-1:0];
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = '{final_beat: 1'b0, run_first: root_first_reg,
                                       tape: TAPE_W'(tape_reg), value: rd0_reg};
                    run_open_next  = 1'b1;
                    i_next         = '0;
                    ret_next       = S_POST;
                    if (!($signed(v_reg) < $signed(rd0_reg))) begin
                        x_next     = v_reg;
                        n_next     = active_reg;
                        state_next = S_SC;
                    end else begin
                        // freeze the value at the end of the active zone
                        we          = 1'b1;
                        wa          = am1[AW-1:0];
                        wd          = v_reg;
                        x_next      = rd1_reg;
                        active_next = am1;
                        n_next      = am1;
                        state_next  = (am1 != '0) ? S_SC : S_POST;
                    end
                end
            end
            S_POST: begin
                if (last_reg) begin
                    frz_next        = hs_reg - active_reg;
                    drn_n_next      = active_reg;
                    drn_first_next  = 1'b0;
                    drn_frozen_next = 1'b0;
                    state_next      = S_DRD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DRD: begin
                if (drn_n_reg == '0) begin
                    if (!drn_frozen_reg && (frz_reg != '0)) begin
                        cp_j_next    = '0;
                        cp_base_next = hs_reg - frz_reg;
                        state_next   = S_CRD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    ra0        = '0;
                    ra1        = nm1[AW-1:0];
                    state_next = S_DRN;
                end
            end
            S_DRN: begin
                ra0 = '0;
                ra1 = nm1[AW-1:0];
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = '{final_beat: (drn_n_reg == CW'(1)) &&
                                                   (drn_frozen_reg || (frz_reg == '0)),
                                       run_first: drn_first_reg,
                                       tape: TAPE_W'(tape_reg), value: rd0_reg};
                    drn_first_next = 1'b0;
                    drn_n_next     = nm1;
                    x_next         = rd1_reg;
                    i_next         = '0;
                    n_next         = nm1;
                    ret_next       = S_DRD;
                    state_next     = (nm1 != '0) ? S_SC : S_DRD;
                end
            end
            S_CRD: begin
                if (cp_j_reg == frz_reg) begin
                    tape_next       = tape_adv;
                    drn_n_next      = frz_reg;
                    drn_first_next  = 1'b1;
                    drn_frozen_next = 1'b1;
                    bld_n_next      = frz_reg;
                    bld_i_next      = frz_reg >> 1;
                    bld_ret_next    = S_DRD;
                    state_next      = S_BLD;
                end else begin
                    ra0        = cp_src[AW-1:0];
                    state_next = S_CWR;
                end
            end
            S_CWR: begin
                we         = 1'b1;
                wa         = cp_j_reg[AW-1:0];
                wd         = rd0_reg;
                cp_j_next  = cp_j_reg + CW'(1);
                state_next = S_CRD;
            end
            S_DONE: begin
                active_next   = '0;
                fill_next     = '0;
                tape_next     = '0;
                run_open_next = 1'b0;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr && (cfg_index == REG_HEAP_SIZE || cfg_index == REG_TAPE_COUNT)) begin
            if (cfg_index == REG_HEAP_SIZE) begin
                hs_next = hs_cfg;
            end else begin
                tc_next = tc_cfg;
            end
            active_next   = '0;
            fill_next     = '0;
            tape_next     = '0;
            run_open_next = 1'b0;
            state_next    = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            hs_reg        <= CW'(HS_RST);
            tc_reg        <= TCW'(TC_RST);
            tape_reg      <= '0;
            active_reg    <= '0;
            fill_reg      <= '0;
            run_open_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hs_reg        <= hs_next;
            tc_reg        <= tc_next;
            tape_reg      <= tape_next;
            active_reg    <= active_next;
            fill_reg      <= fill_next;
            run_open_reg  <= run_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg          <= v_next;
        last_reg       <= last_next;
        x_reg          <= x_next;
        i_reg          <= i_next;
        n_reg          <= n_next;
        ret_reg        <= ret_next;
        bld_i_reg      <= bld_i_next;
        bld_n_reg      <= bld_n_next;
        bld_ret_reg    <= bld_ret_next;
        drn_n_reg      <= drn_n_next;
        drn_first_reg  <= drn_first_next;
        drn_frozen_reg <= drn_frozen_next;
        frz_reg        <= frz_next;
        cp_j_reg       <= cp_j_next;
        cp_base_reg    <= cp_base_next;
        root_first_reg <= root_first_next;
        out_res_reg    <= out_res_next;
    end

    // heap store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[wa] <= wd;
        end
        rd0_reg <= heap_mem[ra0];
        rd1_reg <= heap_mem[ra1];
    end

endmodule

/* test/replacement_selection_run_gen_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replacement_selection_run_gen_tb
// Self-checking bench for the run generator: streams of signed values are
// sent through fill, heap build, run generation with frozen values, and the
// final drain, under several heap sizes and tape counts. A behavioral heap
// model predicts every output beat, which is compared field by field.
// ----------------------------------------------------------------------------
module replacement_selection_run_gen_tb;
    import rsg_pkg::*;

    localparam int DEPTH       = 16;
    localparam int TAPES       = 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  tape;
        logic        run_first;
        logic        final_beat;
    } run_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // in_value[31:0]
    logic s_axis_tlast = 1'b0;        // in_last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // out_value[31:0], out_tape[34:32]
    logic m_axis_tuser;               // run_first
    logic m_axis_tlast;               // out_final

    replacement_selection_run_gen uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- heap model ----------------
    logic [31:0] heap_mem [DEPTH];
    int unsigned heap_n, tape_n, live_n, filled_n, tape_cur;
    bit run_started;
    run_beat_t run_beats_due [$];

    function automatic bit sless(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    task automatic sift_down(int unsigned n, int unsigned i);
        int unsigned s, l, r;
        logic [31:0] t;
        forever begin
            s = i; l = 2 * i + 1; r = 2 * i + 2;
            if (l < n && sless(heap_mem[l], heap_mem[s])) s = l;
            if (r < n && sless(heap_mem[r], heap_mem[s])) s = r;
            if (s == i) break;
            t = heap_mem[i]; heap_mem[i] = heap_mem[s]; heap_mem[s] = t;
            i = s;
        end
    endtask

    task automatic heapify(int unsigned n);
        for (int i = int'(n / 2) - 1; i >= 0; i--) sift_down(n, i);
    endtask

    task automatic push_beat(logic [31:0] v, bit first);
        run_beat_t b;
        b.value = v; b.tape = tape_cur[2:0]; b.run_first = first; b.final_beat = 1'b0;
        run_beats_due.push_back(b);
    endtask

    task automatic pop_all(int unsigned n, bit first);
        while (n > 0) begin
            push_beat(heap_mem[0], first);
            first = 1'b0;
            heap_mem[0] = heap_mem[n - 1];
            n--;
            sift_down(n, 0);
        end
    endtask

    task automatic restart_stream();
        live_n = 0; filled_n = 0; tape_cur = 0; run_started = 1'b0;
    endtask

    task automatic model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        int unsigned v;
        v = 32'(d);
        if (idx == REG_HEAP_SIZE) begin
            heap_n = (v < 1) ? 1 : (v > DEPTH ? DEPTH : v);
            restart_stream();
        end else if (idx == REG_TAPE_COUNT) begin
            v = v & 32'hF;
            tape_n = (v < 1) ? 1 : (v > TAPES ? TAPES : v);
            restart_stream();
        end
    endtask

    task automatic model_beat(logic [31:0] v, bit last);
        int unsigned due_start, frozen;
        logic [31:0] root;
        bit first;
        due_start = run_beats_due.size();
        if (filled_n < heap_n) begin
            heap_mem[filled_n] = v;
            filled_n++;
            if (!last) begin
                if (filled_n == heap_n) begin
                    heapify(heap_n);
                    live_n = heap_n;
                end
                return;
            end
            heapify(filled_n);
            pop_all(filled_n, 1'b1);
        end else begin
            first = !run_started;
            if (live_n == 0) begin
                live_n = heap_n;
                heapify(heap_n);
                if (run_started) tape_cur = (tape_cur + 1) % tape_n;
                first = 1'b1;
            end
            root = heap_mem[0];
            push_beat(root, first);
            run_started = 1'b1;
            if (!sless(v, root)) begin
                heap_mem[0] = v;
            end else begin
                // smaller than the value just emitted: freeze it for the next run
                heap_mem[0] = heap_mem[live_n - 1];
                heap_mem[live_n - 1] = v;
                live_n--;
            end
            sift_down(live_n, 0);
            if (!last) return;
            frozen = heap_n - live_n;
            pop_all(live_n, 1'b0);
            live_n = 0;
            if (frozen > 0) begin
                for (int i = 0; i < int'(frozen); i++) heap_mem[i] = heap_mem[heap_n - frozen + i];
                heapify(frozen);
                tape_cur = (tape_cur + 1) % tape_n;
                pop_all(frozen, 1'b1);
            end
        end
        if (run_beats_due.size() > due_start)
            run_beats_due[run_beats_due.size() - 1].final_beat = 1'b1;
        restart_stream();
    endtask

    // ---------------- driver ----------------
    item_t pending_items [$];
    int unsigned src_idle_pct = 17, sink_idle_pct = 52;
    int unsigned hold_cycles = 0;
    int unsigned items_sent = 0, beats_seen = 0, errors = 0;
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            model_beat(s_axis_tdata, s_axis_tlast);
            items_sent++;
        end
        if ((!s_axis_tvalid || s_axis_tready) && aresetn) begin
            // advance to the next beat, or idle at random
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0].value;
                s_axis_tlast  <= pending_items[0].last;
                void'(pending_items.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (beat %0d)", what, got, want, beats_seen);
    endtask

    always @(posedge aclk) begin
        run_beat_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (run_beats_due.size() == 0) begin
                report("unexpected beat", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = run_beats_due.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report("value", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[34:32] !== want.tape)
                    report("tape", 32'(m_axis_tdata[34:32]), 32'(want.tape));
                if (m_axis_tuser !== want.run_first)
                    report("run_first", 32'(m_axis_tuser), 32'(want.run_first));
                if (m_axis_tlast !== want.final_beat)
                    report("final", 32'(m_axis_tlast), 32'(want.final_beat));
            end
            beats_seen++;
        end
        // long hold-off lets the block back up into its input
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // count down the receiver hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout: %0d beats still due", run_beats_due.size());
            $display("replacement_selection_run_gen_tb: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_stream(int unsigned len);
        item_t it;
        for (int i = 0; i < int'(len); i++) begin
            it.value = rand_value();
            it.last  = (i == int'(len) - 1);
            pending_items.push_back(it);
        end
    endtask

    task automatic add_item(logic [31:0] v, bit last);
        item_t it;
        it.value = v; it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        // sample at the falling edge so that the driver's updates have settled
        while (pending_items.size() > 0 || s_axis_tvalid || run_beats_due.size() > 0)
            @(negedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_config(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int unsigned phase_sizes [6];
        int unsigned phase_tapes [6];
        phase_sizes = '{16, 1, 4, 0, 31, 7};
        phase_tapes = '{2, 1, 8, 0, 15, 3};
        heap_n = 16; tape_n = 2;
        restart_stream();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, equal values, frozen values, last while filling
        write_reg(REG_HEAP_SIZE, 5'd4);
        write_reg(REG_TAPE_COUNT, 5'd3);
        add_item(32'h8000_0000, 1'b0); add_item(32'h7fff_ffff, 1'b1);   // last while filling
        add_item(32'd5, 1'b0); add_item(32'd9, 1'b0);                   // fill
        add_item(32'd1, 1'b0); add_item(32'd7, 1'b0);
        add_item(32'd1, 1'b0);                // equal to emitted minimum: stays in run
        add_item(32'hffff_fff0, 1'b0);        // negative: frozen
        add_item(32'h8000_0000, 1'b0); add_item(32'h8000_0000, 1'b0);
        add_item(32'h8000_0000, 1'b0);        // active zone empties
        add_item(32'h7fff_ffff, 1'b0);        // reheap, new run, next tape
        add_item(32'h5555_5555, 1'b0); add_item(32'haaaa_aaaa, 1'b0);
        add_item(32'h0000_0000, 1'b1);        // last beat: drain the heap
        add_item(32'd3, 1'b1);                // one-beat stream
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_HEAP_SIZE, CFG_DATA_W'(phase_sizes[p]));
            write_reg(REG_TAPE_COUNT, CFG_DATA_W'(phase_tapes[p]));
            if (p < 2) begin src_idle_pct = 17; sink_idle_pct = 52; end
            else if (p < 4) begin src_idle_pct = 52; sink_idle_pct = 17; end
            else begin src_idle_pct = 0; sink_idle_pct = 0; end
            if (p == 5) hold_cycles = LONG_HOLD;
            queue_stream($urandom_range(18, 30));
            if (p != 1) queue_stream($urandom_range(1, 3));
            wait_drained();
        end

        $display("covered %0d input beats and %0d output beats over", items_sent, beats_seen);
        $display("heap sizes 1..16 (incl. clamped writes) and tape counts 1..8");
        if (errors == 0) begin
            $display("replacement_selection_run_gen_tb: PASS");
        end else begin
            $display("replacement_selection_run_gen_tb: FAIL");
        end
        $finish;
    end

endmodule
